@@ hw/rtl/blf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the beam local frame pipeline.
package blf_pkg;

    localparam int UNIT_W   = 32;   // Q1.30 axis component
    localparam int ORIENT_W = 32;   // Q16.16 orientation component
    localparam int LEN_W    = 33;   // Q17.16 beam length
    localparam int RED_W    = 31;   // reduced magnitude before squaring
    localparam int RAD_W    = 64;   // sum of squares
    localparam int ROOT_W   = 32;   // integer square root
    localparam int CROSS_W  = 64;   // raw cross product component
    localparam int NUM_W    = 62;   // divider numerator
    localparam int QUO_W    = 31;   // divider quotient
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 328;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PARALLEL = 2'd2;

    localparam logic [QUO_W-1:0] ONE30   = 31'h4000_0000;
    localparam logic [63:0]      LEN_MAX = 64'h0000_0001_FFFF_FFFF;

    typedef logic signed [UNIT_W-1:0] unit_t;

    typedef struct packed {
        logic        fail;
        logic [63:0] norm16;
    } norm_stat_t;

endpackage

@@ hw/rtl/blf_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module blf_isqrt #(
    parameter int SW = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [blf_pkg::RAD_W-1:0]   in_rad,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [blf_pkg::ROOT_W-1:0]  out_root,
    output logic [SW-1:0]               out_side
);

    localparam int STEPS = blf_pkg::ROOT_W;

    logic                      v_reg    [1:STEPS];
    logic [blf_pkg::RAD_W-1:0] a_reg    [1:STEPS];
    logic [blf_pkg::RAD_W-1:0] r_reg    [1:STEPS];
    logic [SW-1:0]             side_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [blf_pkg::RAD_W-1:0] BIT = 64'd1 << (2 * (STEPS - 1 - k));
        logic                      v_in;
        logic [blf_pkg::RAD_W-1:0] a_in;
        logic [blf_pkg::RAD_W-1:0] r_in;
        logic [SW-1:0]             s_in;
        logic [blf_pkg::RAD_W-1:0] trial;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign a_in = in_rad;
            assign r_in = '0;
            assign s_in = in_side;
        end else begin : g_next
            assign v_in = v_reg[k];
            assign a_in = a_reg[k];
            assign r_in = r_reg[k];
            assign s_in = side_reg[k];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (a_in >= trial) begin
                    a_reg[k+1] <= a_in - trial;
                    r_reg[k+1] <= (r_in >> 1) + BIT;
                end else begin
                    a_reg[k+1] <= a_in;
                    r_reg[k+1] <= r_in >> 1;
                end
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_root  = r_reg[STEPS][blf_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[STEPS];

endmodule

@@ hw/rtl/blf_div.sv @@
`timescale 1ns / 1ps
// Pipelined three-lane restoring divider, one quotient bit per stage.
module blf_div #(
    parameter int SW = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [blf_pkg::NUM_W-1:0]   in_num [3],
    input  logic [blf_pkg::ROOT_W-1:0]  in_den,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [blf_pkg::QUO_W-1:0]   out_quo [3],
    output logic [SW-1:0]               out_side
);

    localparam int STEPS = blf_pkg::QUO_W;

    logic                       v_reg    [1:STEPS];
    logic [blf_pkg::ROOT_W-1:0] den_reg  [1:STEPS];
    logic [blf_pkg::NUM_W-1:0]  rem_reg  [1:STEPS][3];
    logic [blf_pkg::QUO_W-1:0]  quo_reg  [1:STEPS][3];
    logic [SW-1:0]              side_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = STEPS - 1 - k;
        logic                       v_in;
        logic [blf_pkg::ROOT_W-1:0] den_in;
        logic [SW-1:0]              s_in;
        logic [blf_pkg::NUM_W-1:0]  dsh;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign den_in = in_den;
            assign s_in   = in_side;
        end else begin : g_next
            assign v_in   = v_reg[k];
            assign den_in = den_reg[k];
            assign s_in   = side_reg[k];
        end

        assign dsh = blf_pkg::NUM_W'(den_in) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k+1]  <= den_in;
                side_reg[k+1] <= s_in;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [blf_pkg::NUM_W-1:0] rem_in;
            logic [blf_pkg::QUO_W-1:0] quo_in;
            logic                      ge;

            if (k == 0) begin : g_first
                assign rem_in = in_num[l];
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k][l];
                assign quo_in = quo_reg[k][l];
            end

            assign ge = (rem_in >= dsh);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1][l] <= ge ? (rem_in - dsh) : rem_in;
                    quo_reg[k+1][l] <= {quo_in[blf_pkg::QUO_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_side  = side_reg[STEPS];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign out_quo[l] = quo_reg[STEPS][l];
    end

endmodule

@@ hw/rtl/blf_unitize.sv @@
`timescale 1ns / 1ps
// Vector normalization pipeline: range reduction, norm, and per-component divide.
module blf_unitize #(
    parameter int W    = 64,
    parameter int FRAC = 16,
    parameter int SW   = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic [31:0]                zero_threshold,
    input  logic                       in_valid,
    input  logic signed [W-1:0]        in_vec [3],
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output blf_pkg::unit_t             out_unit [3],
    output blf_pkg::norm_stat_t        out_stat,
    output logic [SW-1:0]              out_side
);

    localparam int TW    = $clog2(W + 1);
    localparam int RW    = blf_pkg::RED_W;
    localparam int SQ_SW = 3 * RW + TW + 3 + SW;
    localparam int DV_SW = 3 + 65 + SW;

    // stage A: magnitudes
    logic          a_valid_reg;
    logic [W-1:0]  a_mag_reg [3];
    logic [2:0]    a_sgn_reg;
    logic [SW-1:0] a_side_reg;
    // stage B: reduction shift
    logic          b_valid_reg;
    logic [W-1:0]  b_mag_reg [3];
    logic [TW-1:0] b_shift_reg;
    logic [2:0]    b_sgn_reg;
    logic [SW-1:0] b_side_reg;
    // stage C: reduced magnitudes
    logic          c_valid_reg;
    logic [RW-1:0] c_red_reg [3];
    logic [TW-1:0] c_shift_reg;
    logic [2:0]    c_sgn_reg;
    logic [SW-1:0] c_side_reg;
    // stage D: squares
    logic                 d_valid_reg;
    logic [2*RW-1:0]      d_sq_reg [3];
    logic [RW-1:0]        d_red_reg [3];
    logic [TW-1:0]        d_shift_reg;
    logic [2:0]           d_sgn_reg;
    logic [SW-1:0]        d_side_reg;
    // stage E: sum of squares
    logic                        e_valid_reg;
    logic [blf_pkg::RAD_W-1:0]   e_rad_reg;
    logic [RW-1:0]               e_red_reg [3];
    logic [TW-1:0]               e_shift_reg;
    logic [2:0]                  e_sgn_reg;
    logic [SW-1:0]               e_side_reg;
    // stage F: norm and numerators
    logic                        f_valid_reg;
    logic [blf_pkg::NUM_W-1:0]   f_num_reg [3];
    logic [blf_pkg::ROOT_W-1:0]  f_den_reg;
    logic [DV_SW-1:0]            f_side_reg;
    // stage G: output
    logic                        g_valid_reg;
    blf_pkg::unit_t              g_unit_reg [3];
    blf_pkg::norm_stat_t         g_stat_reg;
    logic [SW-1:0]               g_side_reg;

    logic [W-1:0]  mag [3];
    logic [W-1:0]  mag_or;
    logic [TW-1:0] blen;
    logic [TW-1:0] shift;

    logic                       sq_valid;
    logic [blf_pkg::ROOT_W-1:0] sq_root;
    logic [SQ_SW-1:0]           sq_side;
    logic [RW-1:0]              sq_red [3];
    logic [TW-1:0]              sq_shift;
    logic [2:0]                 sq_sgn;
    logic [SW-1:0]              sq_pass;
    logic [95:0]                wide;
    logic [63:0]                full;
    blf_pkg::norm_stat_t        f_stat;

    logic                       dv_valid;
    logic [blf_pkg::QUO_W-1:0]  dv_quo [3];
    logic [DV_SW-1:0]           dv_side;
    logic [2:0]                 dv_sgn;
    blf_pkg::norm_stat_t        dv_stat;
    logic [SW-1:0]              dv_pass;

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign mag[i] = in_vec[i][W-1] ? unsigned'(-in_vec[i]) : unsigned'(in_vec[i]);
    end

    assign mag_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];

    always_comb begin
        blen = '0;
        for (int i = 0; i < W; i++) begin
            if (mag_or[i]) begin
                blen = TW'(i + 1);
            end
        end
        if (int'(blen) > RW) begin
            shift = TW'(int'(blen) - RW);
        end else begin
            shift = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= sq_valid;
            g_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_mag_reg[i] <= mag[i];
                a_sgn_reg[i] <= in_vec[i][W-1];
                b_mag_reg[i] <= a_mag_reg[i];
                c_red_reg[i] <= RW'(b_mag_reg[i] >> b_shift_reg);
                d_sq_reg[i]  <= c_red_reg[i] * c_red_reg[i];
                d_red_reg[i] <= c_red_reg[i];
                e_red_reg[i] <= d_red_reg[i];
            end
            a_side_reg  <= in_side;
            b_shift_reg <= shift;
            b_sgn_reg   <= a_sgn_reg;
            b_side_reg  <= a_side_reg;
            c_shift_reg <= b_shift_reg;
            c_sgn_reg   <= b_sgn_reg;
            c_side_reg  <= b_side_reg;
            d_shift_reg <= c_shift_reg;
            d_sgn_reg   <= c_sgn_reg;
            d_side_reg  <= c_side_reg;
            e_rad_reg   <= blf_pkg::RAD_W'(d_sq_reg[0]) + blf_pkg::RAD_W'(d_sq_reg[1])
                         + blf_pkg::RAD_W'(d_sq_reg[2]);
            e_shift_reg <= d_shift_reg;
            e_sgn_reg   <= d_sgn_reg;
            e_side_reg  <= d_side_reg;
        end
    end

    blf_isqrt #(
        .SW (SQ_SW)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_rad    (e_rad_reg),
        .in_side   ({e_red_reg[2], e_red_reg[1], e_red_reg[0], e_shift_reg, e_sgn_reg,
                     e_side_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign {sq_red[2], sq_red[1], sq_red[0], sq_shift, sq_sgn, sq_pass} = sq_side;

    // Scale the root back up, saturate to 64 bits, then drop to Q48.16.
    always_comb begin
        wide          = 96'(sq_root) << sq_shift;
        full          = (|wide[95:64]) ? '1 : wide[63:0];
        f_stat.norm16 = full >> (FRAC - 16);
        f_stat.fail   = (sq_root == '0) || (f_stat.norm16 < 64'(zero_threshold));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                f_num_reg[i] <= blf_pkg::NUM_W'({sq_red[i], 30'd0})
                              + blf_pkg::NUM_W'(sq_root >> 1);
            end
            f_den_reg  <= sq_root;
            f_side_reg <= {sq_sgn, f_stat, sq_pass};
        end
    end

    blf_div #(
        .SW (DV_SW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num    (f_num_reg),
        .in_den    (f_den_reg),
        .in_side   (f_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    assign {dv_sgn, dv_stat, dv_pass} = dv_side;

    // Clamp to one, apply the sign, zero the axis on a degenerate norm.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_stat.fail) begin
                    g_unit_reg[i] <= '0;
                end else if (dv_sgn[i]) begin
                    g_unit_reg[i] <= -signed'({1'b0, (dv_quo[i] > blf_pkg::ONE30) ?
                                               blf_pkg::ONE30 : dv_quo[i]});
                end else begin
                    g_unit_reg[i] <= signed'({1'b0, (dv_quo[i] > blf_pkg::ONE30) ?
                                              blf_pkg::ONE30 : dv_quo[i]});
                end
            end
            g_stat_reg <= dv_stat;
            g_side_reg <= dv_pass;
        end
    end

    assign out_valid = g_valid_reg;
    assign out_stat  = g_stat_reg;
    assign out_side  = g_side_reg;
    for (genvar i = 0; i < 3; i++) begin : g_out
        assign out_unit[i] = g_unit_reg[i];
    end

endmodule

@@ hw/rtl/blf_cross.sv @@
`timescale 1ns / 1ps
// Two-stage cross product of two 32-bit vectors: products, then differences.
module blf_cross #(
    parameter int SW = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  blf_pkg::unit_t                     in_a [3],
    input  blf_pkg::unit_t                     in_b [3],
    input  logic [SW-1:0]                      in_side,
    output logic                               out_valid,
    output logic signed [blf_pkg::CROSS_W-1:0] out_w [3],
    output logic [SW-1:0]                      out_side
);

    logic                               p_valid_reg;
    logic signed [blf_pkg::CROSS_W-1:0] p_reg [6];
    logic [SW-1:0]                      p_side_reg;
    logic                               w_valid_reg;
    logic signed [blf_pkg::CROSS_W-1:0] w_reg [3];
    logic [SW-1:0]                      w_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            w_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]   <= in_a[1] * in_b[2];
            p_reg[1]   <= in_a[2] * in_b[1];
            p_reg[2]   <= in_a[2] * in_b[0];
            p_reg[3]   <= in_a[0] * in_b[2];
            p_reg[4]   <= in_a[0] * in_b[1];
            p_reg[5]   <= in_a[1] * in_b[0];
            p_side_reg <= in_side;
            w_reg[0]   <= p_reg[0] - p_reg[1];
            w_reg[1]   <= p_reg[2] - p_reg[3];
            w_reg[2]   <= p_reg[4] - p_reg[5];
            w_side_reg <= p_side_reg;
        end
    end

    assign out_valid = w_valid_reg;
    assign out_side  = w_side_reg;
    for (genvar i = 0; i < 3; i++) begin : g_out
        assign out_w[i] = w_reg[i];
    end

endmodule

@@ hw/rtl/beam_local_frame_core.sv @@
`timescale 1ns / 1ps
// Beam local frame: chord length and orthonormal axes of a 3D beam element.
//
// Input stream (s_*): one transaction carries the start point, end point and
// orientation vector of one element. Output stream (m_*): one transaction
// carries the nine Q1.30 direction cosines, the Q17.16 length and a status
// code in tuser (ok, zero length, orientation parallel to beam).
// The user must load the threshold register through cfg_wr_en / cfg_wr_data only
// while the block is idle; the block does not enforce it. Reset sets it to 1 LSB.
//
// Throughput: one element per cycle while the skid is empty. The path is the
// difference stage, three normalization units (each five range and sum stages,
// a 32-stage square root, a norm and numerator stage, a 31-stage divider and an
// output stage), two 2-stage cross products and the output register. All stages
// advance together; a stalled output is caught by a one-entry skid register, so
// input is still taken after m_tready drops until a result reaches the stalled
// output, then s_tready falls until the skid drains. Nothing is lost or repeated.
// Reset is synchronous and clears every valid bit; data in flight is dropped.
module beam_local_frame_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, orient_x, orient_y, orient_z
    input  logic [((6 * COORD_WIDTH + 3 * blf_pkg::ORIENT_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // axis_x_cx, axis_x_cy, axis_x_cz, axis_y_cx, axis_y_cy, axis_y_cz,
    // axis_z_cx, axis_z_cy, axis_z_cz, beam_length
    output logic [blf_pkg::M_DATA_W-1:0]    m_tdata,
    // status
    output logic [blf_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int DW       = COORD_WIDTH + 1;
    localparam int UW       = blf_pkg::UNIT_W;
    localparam int YSW      = 3 * UW + blf_pkg::LEN_W + 1;
    localparam int ZSW      = 3 * UW + YSW;

    logic [31:0] zero_threshold_reg;
    logic        en;

    logic                          s0_valid_reg;
    logic signed [DW-1:0]          s0_d_reg [3];
    blf_pkg::unit_t                s0_v_reg [3];
    logic signed [COORD_WIDTH-1:0] pt_start [3];
    logic signed [COORD_WIDTH-1:0] pt_end   [3];

    logic                 ux_valid;
    blf_pkg::unit_t       ux_unit [3];
    blf_pkg::norm_stat_t  ux_stat;
    logic [3*UW-1:0]      ux_side;
    blf_pkg::unit_t       ux_v [3];
    logic [blf_pkg::LEN_W-1:0] len_sat;

    logic                               cy_valid;
    logic signed [blf_pkg::CROSS_W-1:0] cy_w [3];
    logic [YSW-1:0]                     cy_side;

    logic                 uy_valid;
    blf_pkg::unit_t       uy_unit [3];
    blf_pkg::norm_stat_t  uy_stat;
    logic [YSW-1:0]       uy_side;
    blf_pkg::unit_t       uy_ex [3];

    logic                               cz_valid;
    logic signed [blf_pkg::CROSS_W-1:0] cz_w [3];
    logic [ZSW-1:0]                     cz_side;

    logic                 uz_valid;
    blf_pkg::unit_t       uz_unit [3];
    blf_pkg::norm_stat_t  uz_stat;
    logic [ZSW-1:0]       uz_side;
    blf_pkg::unit_t       fin_ex [3];
    blf_pkg::unit_t       fin_ey [3];
    logic [blf_pkg::LEN_W-1:0] fin_len;
    logic                 fin_xfail;

    logic                              p_valid;
    logic [blf_pkg::M_DATA_W-1:0]      p_data;
    logic [blf_pkg::STATUS_W-1:0]      p_status;

    logic                              m_tvalid_reg;
    logic [blf_pkg::M_DATA_W-1:0]      m_tdata_reg;
    logic [blf_pkg::STATUS_W-1:0]      m_tuser_reg;
    logic                              skid_valid_reg;
    logic [blf_pkg::M_DATA_W-1:0]      skid_data_reg;
    logic [blf_pkg::STATUS_W-1:0]      skid_user_reg;
    logic                              out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_threshold_reg <= 32'd1;
        end else if (cfg_wr_en) begin
            zero_threshold_reg <= cfg_wr_data;
        end
    end

    // The whole pipeline advances unless the skid register is holding a result.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    for (genvar i = 0; i < 3; i++) begin : g_in
        assign pt_start[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
        assign pt_end[i]   = s_tdata[(3+i)*COORD_WIDTH +: COORD_WIDTH];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s0_d_reg[i] <= DW'(pt_end[i]) - DW'(pt_start[i]);
                s0_v_reg[i] <= s_tdata[6*COORD_WIDTH + i*blf_pkg::ORIENT_W +: blf_pkg::ORIENT_W];
            end
        end
    end

    blf_unitize #(
        .W    (DW),
        .FRAC (16),
        .SW   (3 * UW)
    ) u_unit_x (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .zero_threshold (zero_threshold_reg),
        .in_valid       (s0_valid_reg),
        .in_vec         (s0_d_reg),
        .in_side        ({s0_v_reg[2], s0_v_reg[1], s0_v_reg[0]}),
        .out_valid      (ux_valid),
        .out_unit       (ux_unit),
        .out_stat       (ux_stat),
        .out_side       (ux_side)
    );

    assign {ux_v[2], ux_v[1], ux_v[0]} = ux_side;
    assign len_sat = (ux_stat.norm16 > blf_pkg::LEN_MAX) ? blf_pkg::LEN_MAX[blf_pkg::LEN_W-1:0]
                                                        : ux_stat.norm16[blf_pkg::LEN_W-1:0];

    blf_cross #(
        .SW (YSW)
    ) u_cross_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ux_valid),
        .in_a      (ux_v),
        .in_b      (ux_unit),
        .in_side   ({ux_unit[2], ux_unit[1], ux_unit[0], len_sat, ux_stat.fail}),
        .out_valid (cy_valid),
        .out_w     (cy_w),
        .out_side  (cy_side)
    );

    blf_unitize #(
        .W    (blf_pkg::CROSS_W),
        .FRAC (46),
        .SW   (YSW)
    ) u_unit_y (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .zero_threshold (zero_threshold_reg),
        .in_valid       (cy_valid),
        .in_vec         (cy_w),
        .in_side        (cy_side),
        .out_valid      (uy_valid),
        .out_unit       (uy_unit),
        .out_stat       (uy_stat),
        .out_side       (uy_side)
    );

    assign {uy_ex[2], uy_ex[1], uy_ex[0]} = uy_side[YSW-1:blf_pkg::LEN_W+1];

    blf_cross #(
        .SW (ZSW)
    ) u_cross_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (uy_valid),
        .in_a      (uy_ex),
        .in_b      (uy_unit),
        .in_side   ({uy_unit[2], uy_unit[1], uy_unit[0], uy_side}),
        .out_valid (cz_valid),
        .out_w     (cz_w),
        .out_side  (cz_side)
    );

    blf_unitize #(
        .W    (blf_pkg::CROSS_W),
        .FRAC (60),
        .SW   (ZSW)
    ) u_unit_z (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .zero_threshold (zero_threshold_reg),
        .in_valid       (cz_valid),
        .in_vec         (cz_w),
        .in_side        (cz_side[ZSW-1:0]),
        .out_valid      (uz_valid),
        .out_unit       (uz_unit),
        .out_stat       (uz_stat),
        .out_side       (uz_side)
    );

    assign {fin_ey[2], fin_ey[1], fin_ey[0],
            fin_ex[2], fin_ex[1], fin_ex[0], fin_len, fin_xfail} = uz_side;

    assign p_valid = uz_valid;
    assign p_data  = {7'd0, fin_len,
                      uz_unit[2], uz_unit[1], uz_unit[0],
                      fin_ey[2], fin_ey[1], fin_ey[0],
                      fin_ex[2], fin_ex[1], fin_ex[0]};

    always_comb begin
        if (fin_xfail) begin
            p_status = blf_pkg::STATUS_ZERO_LEN;
        end else if (uz_stat.fail) begin
            p_status = blf_pkg::STATUS_PARALLEL;
        end else begin
            p_status = blf_pkg::STATUS_OK;
        end
    end

    // Output register with a one-entry skid behind it.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (out_free) begin
                m_tvalid_reg <= p_valid;
            end else if (p_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (out_free) begin
                m_tdata_reg <= p_data;
                m_tuser_reg <= p_status;
            end else begin
                skid_data_reg <= p_data;
                skid_user_reg <= p_status;
            end
        end else if (m_tready) begin
            m_tdata_reg <= skid_data_reg;
            m_tuser_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds a result while the output register is empty");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg == blf_pkg::STATUS_OK ||
                          m_tuser_reg == blf_pkg::STATUS_ZERO_LEN ||
                          m_tuser_reg == blf_pkg::STATUS_PARALLEL))
        else $error("undefined status code on output");

    a_zero_len_axes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == blf_pkg::STATUS_ZERO_LEN) |->
        (m_tdata_reg[9*UW-1:0] == '0))
        else $error("zero-length element with nonzero axes");

    a_parallel_z_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == blf_pkg::STATUS_PARALLEL) |->
        (m_tdata_reg[9*UW-1:6*UW] == '0))
        else $error("degenerate orientation with nonzero z axis");

    a_drain_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid not drained after output transaction");

endmodule
